>>> sv/ula_pkg.sv
// shared types and constants of the line assembler
package ula_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] kind_t;

	localparam kind_t KIND_LINE     = 2'd0;
	localparam kind_t KIND_OVERLONG = 2'd1;
	localparam kind_t KIND_TOO_LONG = 2'd2;

	localparam byte_t NL_BYTE = 8'h0A;
	localparam byte_t CR_BYTE = 8'h0D;

	localparam int CAP_W     = 7;
	localparam int LEN_OUT_W = 6;

endpackage

>>> sv/uart_line_assembler_core.sv
// line assembler top level: byte intake, line store control and result output
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry received bytes, one per transaction.
//   Bytes other than newline are stored, one per cycle unless stalled, until the
//   store is full. A newline closes the line; a single trailing CR is dropped.
//   Empty lines give nothing. An error gives one result on m_tuser with
//   m_tlast set and m_tdata zero. A good line is replayed from the store,
//   one byte per transaction, with its length and m_tlast on the final byte.
//   cfg_valid/cfg_data write the capacity register; cfg_ready is always high.
// Timing:
//   A newline that ends a good line holds s_tready low while the store is read
//   out one entry per cycle, unless m_tready stalls it, through the registered
//   read port; emit_q is set, then the store read register loads, then the
//   output register, and m_tvalid rises. An error result is valid from the
//   edge that takes the newline.
//   s_tready is also low while the output register holds a result that the
//   receiver has not taken; a stalled m_tready stalls the replay.
// Reset:
//   arst_n clears the count, discard flag, output valid and sets capacity 64.
//   Store contents are not cleared; only written entries are ever read.
module uart_line_assembler_core #(
	parameter int MAX_LINE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ula_pkg::CAP_W-1:0]    cfg_data,   // out_capacity
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,    // rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata,    // line_byte, line_length, zero pad
	output logic [1:0]                   m_tuser,    // result_kind
	output logic                         m_tlast     // last_of_line
);
	import ula_pkg::*;

	localparam int DEPTH = MAX_LINE - 1;
	localparam int CW    = $clog2(MAX_LINE);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic             discard_q;
	logic             last_cr_q;
	logic             emit_q;
	logic [CW-1:0]    len_q;
	logic [CW-1:0]    rd_idx_q;
	logic             pend_s1;
	logic             rd_last_s1;

	logic             out_valid_q;
	kind_t            out_kind_q;
	byte_t            out_byte_q;
	logic [LEN_OUT_W-1:0] out_len_q;
	logic             out_last_q;

	logic             accept;
	logic             is_nl;
	logic             out_free;
	logic             wr_en;
	logic             rd_en;
	logic             load_rd;
	logic [CW-1:0]    line_len;
	logic [7:0]       line_len8;
	byte_t            rd_data;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = !emit_q && out_free;
	assign accept    = s_tvalid && s_tready;
	assign is_nl     = (s_tdata == NL_BYTE);

	assign line_len  = count_q - CW'((count_q != '0) && last_cr_q);
	assign line_len8 = 8'(line_len);

	assign wr_en   = accept && !is_nl && !discard_q && (32'(count_q) < DEPTH);
	assign load_rd = pend_s1 && out_free;
	assign rd_en   = emit_q && (rd_idx_q < len_q) && (!pend_s1 || out_free);

	ula_line_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(s_tdata),
		.rd_en  (rd_en),
		.rd_addr(rd_idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// intake and line control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			discard_q <= 1'b0;
			last_cr_q <= 1'b0;
			emit_q    <= 1'b0;
			len_q     <= '0;
			rd_idx_q  <= '0;
		end else begin
			if (accept) begin
				if (!is_nl) begin
					if (!discard_q) begin
						if (32'(count_q) >= DEPTH) begin
							discard_q <= 1'b1;
							count_q   <= '0;
						end else begin
							count_q   <= count_q + 1'b1;
							last_cr_q <= (s_tdata == CR_BYTE);
						end
					end
				end else begin
					count_q   <= '0;
					discard_q <= 1'b0;
					if (!discard_q && line_len != '0
							&& line_len8 < {1'b0, cap_q}) begin
						emit_q   <= 1'b1;
						len_q    <= line_len;
						rd_idx_q <= '0;
					end
				end
			end
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (load_rd && rd_last_s1) begin
				emit_q <= 1'b0;
			end
		end
	end

	// read pipeline tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (rd_en) begin
			pend_s1 <= 1'b1;
		end else if (load_rd) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_last_s1 <= (rd_idx_q == len_q - 1'b1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_rd) begin
			out_valid_q <= 1'b1;
		end else if (accept && is_nl && (discard_q
				|| (line_len != '0 && line_len8 >= {1'b0, cap_q}))) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rd) begin
			out_kind_q <= KIND_LINE;
			out_byte_q <= rd_data;
			out_len_q  <= LEN_OUT_W'(8'(len_q));
			out_last_q <= rd_last_s1;
		end else if (accept && is_nl) begin
			out_kind_q <= discard_q ? KIND_OVERLONG : KIND_TOO_LONG;
			out_byte_q <= '0;
			out_len_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {2'b00, out_len_q, out_byte_q};
	assign m_tlast  = out_last_q;

	a_pend_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> emit_q)
		else $error("read data pending outside a replay");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_LINE) |-> (m_tlast && m_tdata == 16'h0000))
		else $error("error result with data or without last");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !pend_s1)
		else $error("last result shown while store data still pending");

	a_no_write_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q |-> !wr_en)
		else $error("store written during a replay");

endmodule

>>> sv/ula_line_mem.sv
// line store: one write port, one registered read port
module ula_line_mem #(
	parameter int DEPTH = 63,
	parameter int AW    = 6
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  ula_pkg::byte_t     wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output ula_pkg::byte_t     rd_data
);
	import ula_pkg::*;

	byte_t mem [DEPTH];
	byte_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> verif/testbench.sv
// testbench for uart_line_assembler_core: directed, store-full and random line traffic
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ula_pkg::*;

	localparam int MAX_LINE       = 64;
	localparam int STORE_DEPTH    = MAX_LINE - 1;
	localparam int SETTLE_CYCLES  = MAX_LINE + 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 60;
	localparam int ITEMS_PER_CAP  = 25;

	typedef struct {
		kind_t                kind;
		byte_t                data;
		logic [LEN_OUT_W-1:0] len;
		logic                 last;
	} line_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CAP_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [15:0]          m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;

	// line assembly state mirrored from the block
	byte_t                line_mem [STORE_DEPTH];
	int unsigned          line_len   = 0;
	bit                   dropping   = 1'b0;
	logic [CAP_W-1:0]     capacity   = 7'd64;

	line_result_t         pending_results [$];
	int                   mismatches     = 0;
	int                   sent_items     = 0;
	int                   send_idle_pct  = 0;
	int                   recv_idle_pct  = 0;
	int                   quiet_cycles   = 0;

	uart_line_assembler_core #(
		.MAX_LINE(MAX_LINE)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	function automatic void push_result(input kind_t kind, input byte_t data,
			input int unsigned len, input logic last);
		line_result_t r;
		r.kind = kind;
		r.data = data;
		r.len  = len[LEN_OUT_W-1:0];
		r.last = last;
		pending_results.push_back(r);
	endfunction

	function automatic void assemble_line(input byte_t b);
		int unsigned n;
		if (b != NL_BYTE) begin
			if (dropping)
				return;
			if (line_len >= STORE_DEPTH) begin
				dropping = 1'b1;
				line_len = 0;
				return;
			end
			line_mem[line_len] = b;
			line_len++;
			return;
		end
		if (dropping) begin
			dropping = 1'b0;
			line_len = 0;
			push_result(KIND_OVERLONG, 8'h00, 0, 1'b1);
			return;
		end
		n = line_len;
		if (n > 0 && line_mem[n-1] == CR_BYTE)
			n--;
		line_len = 0;
		if (n == 0)
			return;
		if (n >= capacity) begin
			push_result(KIND_TOO_LONG, 8'h00, 0, 1'b1);
			return;
		end
		for (int unsigned i = 0; i < n; i++)
			push_result(KIND_LINE, line_mem[i], n, (i + 1 == n));
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_byte(input byte_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		assemble_line(b);
		sent_items++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity = cap;
	endtask

	// line content, never a newline
	task automatic send_line_body(input int n);
		byte_t b;
		repeat (n) begin
			do b = byte_t'($urandom); while (b == NL_BYTE);
			send_byte(b);
		end
	endtask

	task automatic test_directed();
		send_byte(NL_BYTE);
		send_byte(CR_BYTE);
		send_byte(NL_BYTE);
		send_byte(8'h41);
		send_byte(NL_BYTE);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CR_BYTE);
		send_byte(NL_BYTE);
		send_byte(CR_BYTE);
		send_byte(CR_BYTE);
		send_byte(NL_BYTE);
		write_capacity(7'd3);
		send_byte(8'h61);
		send_byte(8'h62);
		send_byte(8'h63);
		send_byte(NL_BYTE);
		send_byte(8'h61);
		send_byte(8'h62);
		send_byte(CR_BYTE);
		send_byte(NL_BYTE);
		write_capacity(7'd0);
		send_byte(8'h78);
		send_byte(NL_BYTE);
	endtask

	task automatic test_store_full();
		write_capacity(7'd64);
		send_line_body(STORE_DEPTH);
		send_byte(NL_BYTE);
		send_line_body(STORE_DEPTH);
		send_byte(CR_BYTE);
		send_byte(NL_BYTE);
		write_capacity(7'd1);
		send_byte(8'h5A);
		send_byte(NL_BYTE);
	endtask

	task automatic send_random_line();
		int pick;
		int n;
		int cap;
		pick = $urandom_range(99);
		cap  = capacity;
		if (pick < 10) begin
			// noise with stray newlines
			repeat ($urandom_range(1, 8))
				send_byte(($urandom_range(3) == 0) ? NL_BYTE : byte_t'($urandom));
			return;
		end
		if (pick < 65)
			n = $urandom_range(0, 10);
		else if (pick < 85)
			n = cap - 2 + $urandom_range(0, 3);
		else
			n = $urandom_range(STORE_DEPTH - 3, STORE_DEPTH + 3);
		if (n < 0)
			n = 0;
		if (n > STORE_DEPTH + 3)
			n = STORE_DEPTH + 3;
		send_line_body(n);
		if ($urandom_range(3) == 0)
			send_byte(CR_BYTE);
		send_byte(NL_BYTE);
	endtask

	task automatic test_random(input int send_pct, input int recv_pct);
		int start_items;
		int cfg_items;
		int pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start_items   = sent_items;
		cfg_items     = sent_items;
		while (sent_items - start_items < RANDOM_ITEMS) begin
			if (sent_items - cfg_items >= ITEMS_PER_CAP) begin
				pick = $urandom_range(99);
				if (pick < 5)
					write_capacity(7'd0);
				else if (pick < 10)
					write_capacity(7'd1);
				else if (pick < 20)
					write_capacity(7'd127);
				else if (pick < 40)
					write_capacity(7'd64);
				else
					write_capacity(CAP_W'($urandom_range(2, 63)));
				cfg_items = sent_items;
			end
			send_random_line();
		end
		wait_idle();
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		line_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending, kind", m_tuser, 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("result_kind", m_tuser, want.kind);
				if (m_tdata[7:0] !== want.data)
					report_mismatch("line_byte", m_tdata[7:0], want.data);
				if (m_tdata[13:8] !== want.len)
					report_mismatch("line_length", m_tdata[13:8], want.len);
				if (m_tlast !== want.last)
					report_mismatch("last_of_line", m_tlast, want.last);
				if (m_tdata[15:14] !== 2'b00)
					report_mismatch("tdata pad", m_tdata[15:14], 0);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("uart_line_assembler_core test failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_directed();
		test_store_full();
		test_random(31, 84);
		test_random(84, 31);
		test_random(0, 0);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());
		if (mismatches == 0) begin
			$display("uart_line_assembler_core test passed");
		end else begin
			$display("uart_line_assembler_core test failed");
		end
		$finish;
	end

endmodule
